// ----- design/rsakr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsakr_pkg
// Shared types and constants for the trial-division key recovery core.
// ----------------------------------------------------------------------------
package rsakr_pkg;

    localparam int WordBits = 32;

    typedef struct packed {
        logic [WordBits-1:0] public_exponent;
        logic [WordBits-1:0] modulus;
    } rsakr_in_t;

    typedef struct packed {
        logic [WordBits-1:0] private_exponent;
        logic                found;
        logic [WordBits-1:0] factor_small;
        logic [WordBits-1:0] factor_large;
    } rsakr_out_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,      // latch e, n; k = 2
        OP_DIV_NK,    // start n / k
        OP_NEXT_K,    // k = k + 1
        OP_SET_P,     // p = k, q = quotient; x = p, k = 2
        OP_DIV_XK,    // start x / k
        OP_SET_XQ,    // x = q, k = 2
        OP_MUL_T,     // t = (p-1)(q-1)
        OP_GCD_INIT,  // a = t, b = e
        OP_DIV_AB,    // start a / b
        OP_GCD_STEP,  // a = b, b = rem
        OP_INV_INIT,  // r0 = t, r1 = e, s0 = 0, s1 = 1
        OP_DIV_R,     // start r0 / r1
        OP_MUL_S,     // start quotient * s1
        OP_INV_STEP,  // euclid update
        OP_FIX_S,     // final correction
        OP_FAIL
    } rsakr_op_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic mul_busy;
        logic rem_zero;
        logic k_over;     // k > x / k, i.e. k*k > x
        logic b_zero;
        logic a_one;
        logic r1_zero;
        logic x_lt2;
    } rsakr_status_t;

endpackage

// ----- design/rsa_key_recovery_trial_division_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_key_recovery_trial_division_core
// Recovers an RSA private exponent from (e, n) by trial division.
// ----------------------------------------------------------------------------
// One key at a time: a new key is taken only once the previous result beat
// has been accepted. Every step (trial divisor, primality test, gcd and
// extended Euclid step) uses a single shared 64-step restoring divider. The
// run time of an item is set by the smallest factor p of the modulus and the
// number s of Euclid steps; each inverse step adds a shift-add multiply that
// takes one quotient bit per cycle. A prime modulus near 2^32 is the worst case.
module rsa_key_recovery_trial_division_core
    import rsakr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rsakr_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rsakr_out_t m_data
);
    rsakr_op_t     op;
    rsakr_status_t status;
    rsakr_out_t    result;

    rsakr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .status(status),
        .result(result), .op(op), .m_data(m_data)
    );

    rsakr_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op), .in_beat(s_data),
        .status(status), .result(result)
    );
endmodule

// ----- design/rsakr_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsakr_divider
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module rsakr_divider
    import rsakr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    logic [63:0] quo_reg, quo_next, rem_reg, rem_next, dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [64:0] trial;

    // one shift-subtract step
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// ----- design/rsakr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsakr_datapath
// Operand registers, shared divider and combinational result for the search.
// ----------------------------------------------------------------------------
module rsakr_datapath
    import rsakr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  rsakr_op_t     op,
    input  rsakr_in_t     in_beat,
    output rsakr_status_t status,
    output rsakr_out_t    result
);
    logic [31:0] e_reg, n_reg, p_reg, q_reg, x_reg, k_reg;
    logic [31:0] e_next, n_next, p_next, q_next, x_next, k_next;
    logic [63:0] t_reg, a_reg, b_reg, t_next, a_next, b_next;
    logic signed [65:0] s0_reg, s1_reg, s0_next, s1_next;
    logic [63:0] mc_reg, mc_next;
    logic signed [65:0] md_reg, md_next, acc_reg, acc_next;
    logic [63:0] dvd, dvs;
    logic        div_start;
    logic [63:0] quo, rem;
    logic        div_busy, div_done;
    logic signed [65:0] s_prod;
    logic signed [65:0] s_fix;
    logic [63:0] t_prod;

    rsakr_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(dvd), .divisor(dvs), .busy(div_busy), .done(div_done),
        .quotient(quo), .remainder(rem)
    );

    // divider operand selection
    always_comb begin
        div_start = 1'b0;
        dvd       = a_reg;
        dvs       = b_reg;
        case (op)
            OP_DIV_NK: begin
                div_start = 1'b1;
                dvd = {32'd0, n_reg};
                dvs = {32'd0, k_reg};
            end
            OP_DIV_XK: begin
                div_start = 1'b1;
                dvd = {32'd0, x_reg};
                dvs = {32'd0, k_reg};
            end
            OP_DIV_AB, OP_DIV_R: div_start = 1'b1;
            default: ;
        endcase
    end

    // shift-add multiply of quotient by s1, one quotient bit per cycle
    always_comb begin
        mc_next  = mc_reg;
        md_next  = md_reg;
        acc_next = acc_reg;
        if (op == OP_MUL_S) begin
            mc_next  = quo;
            md_next  = s1_reg;
            acc_next = 66'sd0;
        end else if (mc_reg != 64'd0) begin
            if (mc_reg[0]) acc_next = acc_reg + md_reg;
            md_next = md_reg <<< 1;
            mc_next = mc_reg >> 1;
        end
    end

    assign t_prod = {32'd0, p_reg - 32'd1} * {32'd0, q_reg - 32'd1};
    assign s_prod = s0_reg - acc_reg;
    assign s_fix  = (s0_reg < 0) ? s0_reg + $signed({2'b00, t_reg}) : s0_reg;

    // register updates per operation
    always_comb begin
        e_next = e_reg; n_next = n_reg; p_next = p_reg; q_next = q_reg;
        x_next = x_reg; k_next = k_reg; t_next = t_reg; a_next = a_reg;
        b_next = b_reg; s0_next = s0_reg; s1_next = s1_reg;
        case (op)
            OP_LOAD: begin
                e_next = in_beat.public_exponent;
                n_next = in_beat.modulus;
                k_next = 32'd2;
            end
            OP_NEXT_K: k_next = k_reg + 32'd1;
            OP_SET_P: begin
                p_next = k_reg;
                q_next = quo[31:0];
                x_next = k_reg;
                k_next = 32'd2;
            end
            OP_SET_XQ: begin
                x_next = q_reg;
                k_next = 32'd2;
            end
            OP_MUL_T: t_next = t_prod;
            OP_GCD_INIT: begin
                a_next = t_reg;
                b_next = {32'd0, e_reg};
            end
            OP_GCD_STEP: begin
                a_next = b_reg;
                b_next = rem;
            end
            // a = t, b = e: r0 = t, r1 = e (the euclid steps reduce e mod t)
            OP_INV_INIT: begin
                a_next  = t_reg;
                b_next  = {32'd0, e_reg};
                s0_next = 66'sd0;
                s1_next = 66'sd1;
            end
            OP_INV_STEP: begin
                a_next  = b_reg;
                b_next  = rem;
                s0_next = s1_reg;
                s1_next = s_prod;
            end
            OP_FIX_S: s0_next = s_fix;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        e_reg <= e_next; n_reg <= n_next; p_reg <= p_next; q_reg <= q_next;
        x_reg <= x_next; k_reg <= k_next; t_reg <= t_next; a_reg <= a_next;
        b_reg <= b_next; s0_reg <= s0_next; s1_reg <= s1_next;
        md_reg <= md_next; acc_reg <= acc_next;
        if (!aresetn) begin
            mc_reg <= '0;
        end else begin
            mc_reg <= mc_next;
        end
    end

    // result: t == 1 gives d = 0
    always_comb begin
        result = '0;
        if (op == OP_FIX_S) begin
            result.found            = 1'b1;
            result.private_exponent = (t_reg == 64'd1) ? 32'd0 : s_fix[31:0];
            result.factor_small     = p_reg;
            result.factor_large     = q_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.mul_busy = (mc_reg != 64'd0);
    assign status.rem_zero = (rem == 64'd0);
    assign status.k_over   = (quo < {32'd0, k_reg});
    assign status.b_zero   = (b_reg == 64'd0);
    assign status.a_one    = (a_reg == 64'd1);
    assign status.r1_zero  = (b_reg == 64'd0);
    assign status.x_lt2    = (x_reg < 32'd2);
endmodule

// ----- design/rsakr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsakr_ctrl
// Sequencer: factor search, two primality tests, gcd, inverse, handshakes.
// ----------------------------------------------------------------------------
module rsakr_ctrl
    import rsakr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rsakr_status_t status,
    input  rsakr_out_t    result,
    output rsakr_op_t     op,
    output rsakr_out_t    m_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCH_W, S_PR, S_PR_W, S_MUL, S_GCD, S_GCD_W,
        S_INV, S_INV_W, S_DONE, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       second_reg, second_next;
    logic       mv_reg, mv_next;
    rsakr_out_t out_reg, out_next;

    // sequencing
    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        mv_next     = mv_reg;
        out_next    = out_reg;
        op          = OP_NONE;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                op         = OP_LOAD;
                state_next = S_SRCH;
            end
            S_SRCH: begin
                op         = OP_DIV_NK;
                state_next = S_SRCH_W;
            end
            S_SRCH_W: if (status.div_done) begin
                if (status.k_over) begin
                    op         = OP_FAIL;
                    state_next = S_OUT;
                    out_next   = '0;
                end else if (status.rem_zero) begin
                    op          = OP_SET_P;
                    second_next = 1'b0;
                    state_next  = S_PR;
                end else begin
                    op         = OP_NEXT_K;
                    state_next = S_SRCH;
                end
            end
            S_PR: begin
                if (status.x_lt2) begin
                    out_next   = '0;
                    state_next = S_OUT;
                end else begin
                    op         = OP_DIV_XK;
                    state_next = S_PR_W;
                end
            end
            S_PR_W: if (status.div_done) begin
                if (status.k_over) begin
                    if (second_reg) begin
                        state_next = S_MUL;
                    end else begin
                        op          = OP_SET_XQ;
                        second_next = 1'b1;
                        state_next  = S_PR;
                    end
                end else if (status.rem_zero) begin
                    out_next   = '0;
                    state_next = S_OUT;
                end else begin
                    op         = OP_NEXT_K;
                    state_next = S_PR;
                end
            end
            S_MUL: begin
                op         = OP_MUL_T;
                state_next = S_GCD;
            end
            S_GCD: begin
                op         = OP_GCD_INIT;
                state_next = S_GCD_W;
            end
            S_GCD_W: begin
                if (status.div_done) begin
                    op = OP_GCD_STEP;
                end else if (!status.div_busy) begin
                    if (status.b_zero) begin
                        if (status.a_one) begin
                            op         = OP_INV_INIT;
                            state_next = S_INV_W;
                        end else begin
                            out_next   = '0;
                            state_next = S_OUT;
                        end
                    end else begin
                        op = OP_DIV_AB;
                    end
                end
            end
            S_INV_W: begin
                if (status.div_done) begin
                    op         = OP_MUL_S;
                    state_next = S_INV;
                end else if (!status.div_busy) begin
                    if (status.r1_zero) state_next = S_DONE;
                    else op = OP_DIV_R;
                end
            end
            S_DONE: begin
                op         = OP_FIX_S;
                out_next   = result;
                state_next = S_OUT;
            end
            S_OUT: if (!mv_reg) begin
                mv_next    = 1'b1;
                state_next = S_IDLE;
            end
            // wait for the quotient times s1 product
            S_INV: if (!status.mul_busy) begin
                op         = OP_INV_STEP;
                state_next = S_INV_W;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
            mv_reg     <= mv_next;
        end
    end

    // a new key only once the previous result beat has gone
    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !mv_reg) |=> mv_reg) else $error("result lost");
    a_found_fac: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && out_reg.found) |-> (out_reg.factor_small >= 32'd2))
        else $error("found without factor");
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !out_reg.found) |-> (out_reg.private_exponent == 32'd0))
        else $error("not found but d set");
`endif
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the trial-division RSA key recovery core.
// ----------------------------------------------------------------------------
// A short table of keys comes first: fixed answers where they are obvious,
// otherwise a behavioural predictor supplies them. Random keys follow. Most
// of them are built as a product of a small factor and a cofactor, so the
// primality, gcd and inverse paths all get exercised. Both sides of the core
// idle in random bursts. Every result beat is checked field by field against
// the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_top;
    import rsakr_pkg::*;

    localparam int NumRandom   = 80;
    localparam int QuietTail   = 15;
    localparam longint MaxCycles = 40_000_000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    rsakr_in_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    rsakr_out_t m_data;

    rsakr_out_t pending_keys[$];
    int         mismatches = 0;
    longint     cycles = 0;
    bit         quiet = 1'b0;
    int         out_stall = 0;

    typedef struct {
        logic [31:0] e;
        logic [31:0] n;
        bit          fixed;
        rsakr_out_t  res;
    } key_row_t;

    localparam rsakr_out_t NotFound = '0;

    key_row_t key_table[] = '{
        '{32'd0,          32'd0,          1'b1, NotFound},
        '{32'hFFFF_FFFF,  32'd1,          1'b1, NotFound},
        '{32'd3,          32'd2,          1'b1, NotFound},
        '{32'd3,          32'd3,          1'b1, NotFound},
        '{32'd0,          32'd4,          1'b1, '{32'd0, 1'b1, 32'd2, 32'd2}},
        '{32'd3,          32'd15,         1'b1, '{32'd3, 1'b1, 32'd3, 32'd5}},
        '{32'd2,          32'd15,         1'b1, NotFound},
        '{32'd3,          32'd7,          1'b1, NotFound},
        '{32'd5,          32'd12,         1'b1, NotFound},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, NotFound},
        '{32'd7,          32'h8000_0000,  1'b1, NotFound},
        '{32'd0,          32'd15,         1'b1, NotFound},
        '{32'd65537,      32'd3233,       1'b0, NotFound},
        '{32'hFFFF_FFFF,  32'd3233,       1'b0, NotFound},
        '{32'h8000_0001,  32'd10403,      1'b0, NotFound},
        '{32'd17,         32'd65521,      1'b0, NotFound},
        '{32'd65537,      32'd2_147_470,  1'b0, NotFound},
        '{32'd11,         32'd6,          1'b0, NotFound},
        '{32'd5,          32'd9,          1'b0, NotFound}
    };

    rsa_key_recovery_trial_division_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // primality by trial division
    function automatic bit is_prime(longint unsigned x);
        longint unsigned k;
        if (x < 2) return 1'b0;
        for (k = 2; k <= x / k; k++) begin
            if (x % k == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic longint unsigned gcd(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // inverse of e modulo m by extended euclid, result in 0..m-1
    function automatic longint unsigned inverse_mod(longint unsigned e, longint unsigned m);
        longint r0, r1, s0, s1, qt, tr, ts;
        r0 = longint'(m);
        r1 = longint'(e % m);
        s0 = 0;
        s1 = 1;
        while (r1 != 0) begin
            qt = r0 / r1;
            tr = r0 - qt * r1;
            ts = s0 - qt * s1;
            r0 = r1;
            r1 = tr;
            s0 = s1;
            s1 = ts;
        end
        if (m == 1) return 0;
        if (s0 < 0) s0 += longint'(m);
        return longint'(s0) % m;
    endfunction

    // expected answer for one public key
    function automatic rsakr_out_t recover_key(logic [31:0] e, logic [31:0] n);
        rsakr_out_t      res;
        longint unsigned nn, p, q, t, k;
        res = '0;
        nn = 64'(n);
        p = 0;
        for (k = 2; k <= nn / k; k++) begin
            if (nn % k == 0) begin
                p = k;
                break;
            end
        end
        if (p == 0) return res;
        q = nn / p;
        if (!is_prime(p) || !is_prime(q)) return res;
        t = (p - 1) * (q - 1);
        if (gcd(t, 64'(e)) != 1) return res;
        res.private_exponent = 32'(inverse_mod(64'(e), t));
        res.found = 1'b1;
        res.factor_small = 32'(p);
        res.factor_large = 32'(q);
        return res;
    endfunction

    // send one key and queue its expected answer on acceptance
    task automatic send_key(logic [31:0] e, logic [31:0] n, bit fixed, rsakr_out_t res);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{public_exponent: e, modulus: n};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_keys.push_back(fixed ? res : recover_key(e, n));
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_ready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall <= $urandom_range(0, 8);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        rsakr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_keys.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", m_data);
            end else begin
                want = pending_keys.pop_front();
                if (m_data.private_exponent !== want.private_exponent
                        || m_data.found !== want.found
                        || m_data.factor_small !== want.factor_small
                        || m_data.factor_large !== want.factor_large) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MaxCycles) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0] e, n, p, q;
        int          kind;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed keys
        foreach (key_table[i])
            send_key(key_table[i].e, key_table[i].n, key_table[i].fixed, key_table[i].res);

        // random keys
        for (int i = 0; i < NumRandom; i++) begin
            if (i == NumRandom / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_keys.size() != 0) @(posedge aclk);
            end
            if (i == NumRandom - QuietTail) quiet = 1'b1;
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: e = $urandom_range(2, 70000);
                2: e = 32'd65537;
                default: e = $urandom;
            endcase
            if (kind < 8) begin
                // small factor times cofactor up to sixteen bits
                p = $urandom_range(2, 255);
                q = $urandom_range(2, 65535);
                n = p * q;
            end else begin
                n = $urandom_range(0, 65535);
            end
            send_key(e, n, 1'b0, NotFound);
        end
        s_valid <= 1'b0;

        // drain
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
